// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every edge outside of reset.
`define ASSERT_ON(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/ceu_pkg.sv -----
// ----------------------------------------------------------------------------
// ceu_pkg
// Shared types and constants of the C escape decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ceu_pkg;

  // Most decoded bytes one input byte can produce.
  localparam int unsigned GROUP_MAX = 3;
  localparam int unsigned GROUP_CNT_W = $clog2(GROUP_MAX + 1);
  localparam int unsigned GROUP_IDX_W = $clog2(GROUP_MAX);

  // Default depth of the queue between decoder and serializer, in groups.
  localparam int unsigned FIFO_DEPTH = 4;

  // Escape decoder phase.
  typedef enum logic [2:0] {
    PH_PLAIN = 3'd0,
    PH_ESC   = 3'd1,
    PH_HEX0  = 3'd2,
    PH_HEX1  = 3'd3,
    PH_OCT   = 3'd4
  } phase_t;

  // Decoded bytes produced by one input byte, oldest at index 0.
  typedef struct packed {
    logic [GROUP_CNT_W-1:0]          count;
    logic [GROUP_MAX-1:0][7:0]       data;
    logic                            last;
  } group_t;

endpackage

`default_nettype wire

// ----- hdl/ceu_front.sv -----
// ----------------------------------------------------------------------------
// ceu_front
// Escape decoder: takes one raw byte per transfer and forms a group of
// zero to three decoded bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module ceu_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           accept,
  input  wire logic [7:0]     in_byte,
  input  wire logic           in_last,
  output ceu_pkg::group_t     grp,
  output logic                grp_valid
);

  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChLowerX    = 8'h78;
  localparam logic [7:0] ChUpperX    = 8'h58;
  localparam logic [7:0] ChZero      = 8'h30;
  localparam logic [7:0] ChSeven     = 8'h37;
  localparam logic [7:0] ChNine      = 8'h39;
  localparam logic [7:0] ChLowerA    = 8'h61;
  localparam logic [7:0] ChLowerF    = 8'h66;
  localparam logic [7:0] ChUpperA    = 8'h41;
  localparam logic [7:0] ChUpperF    = 8'h46;
  localparam logic [7:0] ChLowerR    = 8'h72;
  localparam logic [7:0] ChLowerN    = 8'h6E;
  localparam logic [7:0] ChLowerT    = 8'h74;
  localparam logic [7:0] ChLowerB    = 8'h62;
  localparam logic [7:0] ChLowerV    = 8'h76;
  localparam logic [7:0] CtlCr       = 8'd13;
  localparam logic [7:0] CtlLf       = 8'd10;
  localparam logic [7:0] CtlTab      = 8'd9;
  localparam logic [7:0] CtlBell     = 8'd7;
  localparam logic [7:0] CtlBs       = 8'd8;
  localparam logic [7:0] CtlFf       = 8'd12;
  localparam logic [7:0] CtlVt       = 8'd11;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= ChZero && c <= ChNine) || (c >= ChLowerA && c <= ChLowerF) ||
           (c >= ChUpperA && c <= ChUpperF);
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    if (c <= ChNine) begin
      v = c - ChZero;
    end else if (c >= ChLowerA) begin
      v = c - ChLowerA + 8'd10;
    end else begin
      v = c - ChUpperA + 8'd10;
    end
    return v[3:0];
  endfunction

  function automatic logic is_oct(input logic [7:0] c);
    return c >= ChZero && c <= ChSeven;
  endfunction

  ceu_pkg::phase_t phase, phase_next;
  logic [8:0]  oacc, oacc_next;
  logic [1:0]  ocnt, ocnt_next;
  logic [7:0]  held, held_next;

  logic [ceu_pkg::GROUP_CNT_W-1:0] n;
  logic [7:0]  d0, d1, d2;
  logic        pb_emit;
  ceu_pkg::phase_t pb_phase;
  logic [8:0]  oacc_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= ceu_pkg::PH_PLAIN;
      oacc  <= '0;
      ocnt  <= '0;
      held  <= '0;
    end else if (accept) begin
      phase <= phase_next;
      oacc  <= oacc_next;
      ocnt  <= ocnt_next;
      held  <= held_next;
    end
  end

  always_comb begin
    // plain-text handling of the current byte; a backslash not marked last
    // opens an escape and emits nothing
    pb_emit    = !(in_byte == ChBackslash && !in_last);
    pb_phase   = pb_emit ? ceu_pkg::PH_PLAIN : ceu_pkg::PH_ESC;
    oacc_shift = {oacc[5:0], in_byte[2:0]};

    phase_next = phase;
    oacc_next  = oacc;
    ocnt_next  = ocnt;
    held_next  = held;
    n          = '0;
    d0         = in_byte;
    d1         = in_byte;
    d2         = in_byte;

    unique case (phase)
      ceu_pkg::PH_ESC: begin
        phase_next = ceu_pkg::PH_PLAIN;
        n = ceu_pkg::GROUP_CNT_W'(1);
        priority case (in_byte)
          ChLowerR: d0 = CtlCr;
          ChLowerN: d0 = CtlLf;
          ChLowerT: d0 = CtlTab;
          ChLowerA: d0 = CtlBell;
          ChLowerB: d0 = CtlBs;
          ChLowerF: d0 = CtlFf;
          ChLowerV: d0 = CtlVt;
          ChLowerX, ChUpperX: begin
            d0 = ChLowerX;
            if (!in_last) begin
              n = '0;
              phase_next = ceu_pkg::PH_HEX0;
            end
          end
          default: begin
            if (is_oct(in_byte)) begin
              d0 = {5'd0, in_byte[2:0]};
              if (in_last) begin
                oacc_next = '0;
                ocnt_next = '0;
              end else begin
                n = '0;
                oacc_next = {6'd0, in_byte[2:0]};
                ocnt_next = 2'd1;
                phase_next = ceu_pkg::PH_OCT;
              end
            end
          end
        endcase
      end
      ceu_pkg::PH_HEX0: begin
        d0 = ChLowerX;
        if (is_hex(in_byte)) begin
          if (in_last) begin
            n = ceu_pkg::GROUP_CNT_W'(2);
            phase_next = ceu_pkg::PH_PLAIN;
          end else begin
            held_next = in_byte;
            phase_next = ceu_pkg::PH_HEX1;
          end
        end else begin
          n = pb_emit ? ceu_pkg::GROUP_CNT_W'(2) : ceu_pkg::GROUP_CNT_W'(1);
          phase_next = pb_phase;
        end
      end
      ceu_pkg::PH_HEX1: begin
        held_next = '0;
        if (is_hex(in_byte)) begin
          d0 = {hex_value(held), hex_value(in_byte)};
          n = ceu_pkg::GROUP_CNT_W'(1);
          phase_next = ceu_pkg::PH_PLAIN;
        end else begin
          // bad hex: 'x', the held digit, then this byte as plain text
          d0 = ChLowerX;
          d1 = held;
          n = pb_emit ? ceu_pkg::GROUP_CNT_W'(3) : ceu_pkg::GROUP_CNT_W'(2);
          phase_next = pb_phase;
        end
      end
      ceu_pkg::PH_OCT: begin
        if (is_oct(in_byte) && ocnt != 2'd3) begin
          if (ocnt == 2'd2 || in_last) begin
            d0 = oacc_shift[7:0];
            n = ceu_pkg::GROUP_CNT_W'(1);
            oacc_next = '0;
            ocnt_next = '0;
            phase_next = ceu_pkg::PH_PLAIN;
          end else begin
            oacc_next = oacc_shift;
            ocnt_next = ocnt + 2'd1;
          end
        end else begin
          d0 = oacc[7:0];
          n = pb_emit ? ceu_pkg::GROUP_CNT_W'(2) : ceu_pkg::GROUP_CNT_W'(1);
          oacc_next = '0;
          ocnt_next = '0;
          phase_next = pb_phase;
        end
      end
      default: begin
        if (pb_emit) begin
          n = ceu_pkg::GROUP_CNT_W'(1);
        end
        phase_next = pb_phase;
      end
    endcase

    grp.count = n;
    grp.data  = {d2, d1, d0};
    grp.last  = in_last;
    grp_valid = accept && (n != '0);
  end

endmodule

`default_nettype wire

// ----- hdl/ceu_fifo.sv -----
// ----------------------------------------------------------------------------
// ceu_fifo
// Short queue of decoded groups between decoder and serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module ceu_fifo #(
  parameter int unsigned Depth = ceu_pkg::FIFO_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            wr_en,
  input  wire ceu_pkg::group_t wr_data,
  input  wire logic            rd_en,
  output ceu_pkg::group_t      rd_data,
  output logic                 full,
  output logic                 empty
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ceu_pkg::group_t mem [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  logic do_wr, do_rd;

  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CntW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CntW'(1);
      end
    end
  end

  assign rd_data = mem[rd_ptr];
  assign full    = (count == CntW'(Depth));
  assign empty   = (count == '0);

endmodule

`default_nettype wire

// ----- hdl/ceu_back.sv -----
// ----------------------------------------------------------------------------
// ceu_back
// Serializer: walks the head group one byte per transfer and releases the
// group after its final byte.
// ----------------------------------------------------------------------------
`default_nettype none

module ceu_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire ceu_pkg::group_t head,
  input  wire logic            head_empty,
  input  wire logic            pop,
  output logic                 head_pop,
  output logic [7:0]           out_byte,
  output logic                 run_last,
  output logic                 message_last
);

  logic [ceu_pkg::GROUP_IDX_W-1:0] idx;
  logic                            xfer;

  assign xfer         = pop && !head_empty;
  assign out_byte     = head.data[idx];
  assign run_last     = (ceu_pkg::GROUP_CNT_W'(idx) ==
                         head.count - ceu_pkg::GROUP_CNT_W'(1));
  assign message_last = run_last && head.last;
  assign head_pop     = xfer && run_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (xfer) begin
      idx <= run_last ? '0 : idx + ceu_pkg::GROUP_IDX_W'(1);
    end
  end

endmodule

`default_nettype wire

// ----- hdl/c_escape_unescaper.sv -----
// ----------------------------------------------------------------------------
// c_escape_unescaper
// Decodes C backslash escapes in a byte stream, message by message.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive in_byte/in_last and raise push; the byte transfers
//   on a clock edge with push high and full low. in_last marks the final
//   byte of a message; any pending escape is closed out on that byte.
//   Result channel: while empty is low, out_byte/run_last/message_last show
//   the oldest decoded byte; it transfers on an edge with pop high.
//   run_last flags the final result caused by one input byte; message_last
//   flags the final decoded byte of a message.
// Timing:
//   One input byte per cycle while full is low. With the queue empty, the
//   first decoded byte of an input is visible the cycle after its transfer.
//   Each input byte yields 0 to 3 results, drained one per cycle while pop is
//   high. A FifoDepth-group queue absorbs bursts; full rises when it fills.
// Reset: rst clears the decoder state and the queue; empty is high after.
// Stall: with pop low, results hold and input keeps transferring until the
//   queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module c_escape_unescaper #(
  parameter int unsigned FifoDepth = ceu_pkg::FIFO_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_last,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_byte,
  output logic             run_last,
  output logic             message_last
);

  ceu_pkg::group_t grp, head;
  logic            grp_valid;
  logic            head_pop;
  logic            accept;

  assign accept = push && !full;

  ceu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .grp       (grp),
    .grp_valid (grp_valid)
  );

  ceu_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (grp_valid),
    .wr_data (grp),
    .rd_en   (head_pop),
    .rd_data (head),
    .full    (full),
    .empty   (empty)
  );

  ceu_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .head_empty   (empty),
    .pop          (pop),
    .head_pop     (head_pop),
    .out_byte     (out_byte),
    .run_last     (run_last),
    .message_last (message_last)
  );

  // queued groups always carry at least one byte
  `ASSERT_ON(a_head_nonzero, clk, rst, !empty |-> (head.count != '0), "empty group queued")
  // queue comes out of reset drained
  `ASSERT_ALWAYS(a_reset_empty, clk, rst |=> empty, "queue not empty after reset")
  // a full queue must be presenting a result
  `ASSERT_ON(a_full_not_empty, clk, rst, full |-> !empty, "full and empty together")

endmodule

`default_nettype wire

// ----- dv/c_escape_unescaper_checker.sv -----
// ----------------------------------------------------------------------------
// c_escape_unescaper_checker
// Watches both channels of the escape decoder, predicts every decoded byte
// from the accepted input bytes, and compares each popped result in order.
// ----------------------------------------------------------------------------
module c_escape_unescaper_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       empty,
  input  logic       pop,
  input  logic [7:0] out_byte,
  input  logic       run_last,
  input  logic       message_last,
  output int         fail_count,
  output int         pending
);

  typedef enum logic [2:0] {
    ST_TEXT,
    ST_ESC,
    ST_HEX_HI,
    ST_HEX_LO,
    ST_OCTAL
  } esc_state_t;

  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       msg_end;
  } decoded_t;

  localparam int unsigned MAX_PER_BYTE = 3;

  esc_state_t phase;
  logic [8:0] oct_val;
  logic [1:0] oct_cnt;
  logic [7:0] hex_hi;

  logic [7:0] group_q[$];
  decoded_t   decoded_q[$];
  decoded_t   want;

  function automatic bit is_hex(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic bit is_oct(input logic [7:0] c);
    return c >= "0" && c <= "7";
  endfunction

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    if (c <= "9") return 4'(c - "0");
    if (c >= "a") return 4'(c - "a" + 10);
    return 4'(c - "A" + 10);
  endfunction

  function void emit(input logic [7:0] b);
    if (group_q.size() < MAX_PER_BYTE) group_q = {group_q, b};
  endfunction

  function void octal_flush();
    emit(oct_val[7:0]);
    oct_val = '0;
    oct_cnt = '0;
  endfunction

  function void text_byte(input logic [7:0] b, input logic fin);
    if (b == "\\") begin
      if (fin) begin
        emit("\\");
        phase = ST_TEXT;
      end else begin
        phase = ST_ESC;
      end
    end else begin
      emit(b);
      phase = ST_TEXT;
    end
  endfunction

  function void after_backslash(input logic [7:0] b, input logic fin);
    phase = ST_TEXT;
    case (b)
      "r": emit(8'd13);
      "n": emit(8'd10);
      "t": emit(8'd9);
      "a": emit(8'd7);
      "b": emit(8'd8);
      "f": emit(8'd12);
      "v": emit(8'd11);
      "x", "X": begin
        if (fin) emit("x");
        else phase = ST_HEX_HI;
      end
      default: begin
        if (is_oct(b)) begin
          oct_val = {6'd0, b[2:0]};
          oct_cnt = 2'd1;
          if (fin) octal_flush();
          else phase = ST_OCTAL;
        end else begin
          emit(b);
        end
      end
    endcase
  endfunction

  // Expected results of one transferred input byte, appended to decoded_q.
  function void decode_byte(input logic [7:0] b, input logic fin);
    decoded_t r;
    group_q.delete();
    case (phase)
      ST_ESC: after_backslash(b, fin);
      ST_HEX_HI: begin
        if (is_hex(b)) begin
          if (fin) begin
            emit("x");
            text_byte(b, 1'b1);
          end else begin
            hex_hi = b;
            phase = ST_HEX_LO;
          end
        end else begin
          emit("x");
          text_byte(b, fin);
        end
      end
      ST_HEX_LO: begin
        if (is_hex(b)) begin
          emit({hex_nibble(hex_hi), hex_nibble(b)});
          phase = ST_TEXT;
        end else begin
          // bad hex: held digit and this byte go back through as plain input
          emit("x");
          text_byte(hex_hi, 1'b0);
          text_byte(b, fin);
        end
        hex_hi = '0;
      end
      ST_OCTAL: begin
        if (is_oct(b) && oct_cnt < 2'd3) begin
          oct_val = {oct_val[5:0], b[2:0]};
          oct_cnt = oct_cnt + 2'd1;
          if (oct_cnt == 2'd3 || fin) begin
            octal_flush();
            phase = ST_TEXT;
          end
        end else begin
          octal_flush();
          text_byte(b, fin);
        end
      end
      default: text_byte(b, fin);
    endcase
    for (int k = 0; k < group_q.size(); k++) begin
      r.data    = group_q[k];
      r.run_end = (k == group_q.size() - 1);
      r.msg_end = r.run_end && fin;
      decoded_q = {decoded_q, r};
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      phase = ST_TEXT;
      oct_val = '0;
      oct_cnt = '0;
      hex_hi = '0;
      decoded_q.delete();
      fail_count = 0;
    end else begin
      if (push && !full) decode_byte(in_byte, in_last);
      if (pop && !empty) begin
        if (decoded_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result byte=%02h run_last=%0b message_last=%0b",
                     $realtime, out_byte, run_last, message_last);
        end else begin
          want = decoded_q.pop_front();
          if (out_byte !== want.data || run_last !== want.run_end ||
              message_last !== want.msg_end) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch byte exp %02h got %02h, run_last exp %0b got %0b, %s",
                       $realtime, want.data, out_byte, want.run_end, run_last,
                       $sformatf("message_last exp %0b got %0b", want.msg_end, message_last));
          end
        end
      end
    end
    pending = decoded_q.size();
  end

endmodule

// ----- dv/c_escape_unescaper_test.sv -----
// ----------------------------------------------------------------------------
// c_escape_unescaper_test
// Drives escaped text into the decoder: a directed set of corner cases, then
// random messages of good and broken escapes and raw bytes, with random idling
// on both channels. The checker predicts and compares every result.
// ----------------------------------------------------------------------------
module c_escape_unescaper_test;

  localparam int unsigned ITEM_TARGET = 170;
  localparam int unsigned LONG_HOLD   = 80;
  localparam int unsigned TAIL_CYCLES = 20;
  localparam int unsigned MAX_CYCLES  = 300000;

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  logic [7:0] in_byte;
  logic       in_last;
  logic       empty;
  logic       pop;
  logic [7:0] out_byte;
  logic       run_last;
  logic       message_last;
  int         fail_count;
  int         pending;

  bit         tx_burst;
  bit         rx_burst;
  bit         rx_long_hold;
  int         hold;
  int         sent;
  int         msg_idx;
  int         target;
  logic [7:0] msg_q[$];

  string simple_chars = "rntabfv'\"\\";
  string hex_chars    = "0123456789abcdefABCDEF";
  string non_hex      = "\\gz!xX\"@~";

  c_escape_unescaper dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .in_byte      (in_byte),
    .in_last      (in_last),
    .empty        (empty),
    .pop          (pop),
    .out_byte     (out_byte),
    .run_last     (run_last),
    .message_last (message_last)
  );

  c_escape_unescaper_checker chk (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .in_byte      (in_byte),
    .in_last      (in_last),
    .empty        (empty),
    .pop          (pop),
    .out_byte     (out_byte),
    .run_last     (run_last),
    .message_last (message_last),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Mostly no gap, some short, a few long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = tx_burst ? 0 : idle_len();
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    push = 1'b1;
    in_byte = b;
    in_last = fin;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  function void append_byte(input logic [7:0] b);
    msg_q = {msg_q, b};
  endfunction

  function void add_token();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      append_byte(8'($urandom_range(0, 255)));
    end else if (r < 45) begin
      append_byte("\\");
      append_byte(simple_chars[$urandom_range(0, 9)]);
    end else if (r < 60) begin
      append_byte("\\");
      append_byte($urandom_range(0, 1) ? "x" : "X");
      append_byte(hex_chars[$urandom_range(0, 21)]);
      append_byte(hex_chars[$urandom_range(0, 21)]);
    end else if (r < 72) begin
      append_byte("\\");
      repeat ($urandom_range(1, 3)) append_byte({5'b00110, 3'($urandom_range(0, 7))});
    end else if (r < 82) begin
      // broken hex escape
      append_byte("\\");
      append_byte($urandom_range(0, 1) ? "x" : "X");
      if ($urandom_range(0, 1)) append_byte(hex_chars[$urandom_range(0, 21)]);
      append_byte(non_hex[$urandom_range(0, non_hex.len() - 1)]);
    end else if (r < 92) begin
      append_byte("\\");
      append_byte(8'($urandom_range(0, 255)));
    end else begin
      append_byte("\\");
    end
  endfunction

  // Result side; a long hold is requested by the stimulus through rx_long_hold.
  initial begin
    pop = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        pop = 1'b0;
        hold--;
      end else if (rx_long_hold) begin
        rx_long_hold = 1'b0;
        pop = 1'b0;
        hold = LONG_HOLD - 1;
      end else if (rx_burst) begin
        pop = 1'b1;
      end else begin
        hold = idle_len();
        pop = (hold == 0);
        if (hold > 0) hold--;
      end
    end
  end

  initial begin
    rst = 1'b1;
    push = 1'b0;
    in_byte = '0;
    in_last = 1'b0;
    tx_burst = 1'b0;
    rx_burst = 1'b0;
    rx_long_hold = 1'b0;
    sent = 0;
    msg_idx = 0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("\\x4F\\Xg");
    send_text("\\x5\\n\\777\\18\\9\\");
    send_text("\\x");

    while (sent < ITEM_TARGET) begin
      msg_q.delete();
      target = (msg_idx == 3) ? 14 : $urandom_range(1, 14);
      while (msg_q.size() < target) add_token();
      // drop the last byte of some messages, which can cut them mid-escape
      if (msg_q.size() > 1 && $urandom_range(0, 4) == 0) void'(msg_q.pop_back());
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      if (msg_idx == 3) begin
        rx_long_hold = 1'b1;
        tx_burst = 1'b1;
      end
      if (msg_idx == 8) begin
        push = 1'b0;
        wait (pending == 0);
      end
      foreach (msg_q[i]) send_byte(msg_q[i], i == msg_q.size() - 1);
      msg_idx++;
    end

    push = 1'b0;
    in_last = 1'b0;
    rx_burst = 1'b1;
    wait (pending == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    repeat (MAX_CYCLES) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
